/* rtl/core/mnpd_pkg.sv */
// ----------------------------------------------------------------------------
// mnpd_pkg: shared constants and types of the negative peak detector
// Field widths, register indexes, reset values and the layout of one
// per-channel state entry.
// ----------------------------------------------------------------------------
package mnpd_pkg;

   // Channel count and state memory addressing
   localparam int CHANNELS = 512;
   localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Field widths
   localparam int CH_W     = 9;
   localparam int SAMPLE_W = 16;
   localparam int NUM_W    = 47;
   localparam int PNUM_W   = 48;
   localparam int GAP_W    = 49;
   localparam int CNT_W    = 8;
   localparam int REFR_W   = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REFRACTORY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PEAKS  = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET  = -16'sd400;
   localparam logic [REFR_W-1:0]          REFRACTORY_RESET = 16'd30;
   localparam logic [CNT_W-1:0]           MAX_PEAKS_RESET  = 8'd10;

   // Per-channel state entry
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] older_sample;
      logic signed [SAMPLE_W-1:0] previous_sample;
      logic signed [PNUM_W-1:0]   previous_number;
      logic signed [PNUM_W-1:0]   last_peak_number;
      logic [CNT_W-1:0]           block_peak_count;
   } chs_entry_type;

   localparam int ENTRY_W = $bits(chs_entry_type);

   // previous number is minus one, last peak is minus two to the 46th
   localparam chs_entry_type ENTRY_RESET = '{
      older_sample:     16'sd0,
      previous_sample:  16'sd0,
      previous_number:  48'hFFFF_FFFF_FFFF,
      last_peak_number: 48'hC000_0000_0000,
      block_peak_count: 8'd0
   };

   // Map a channel index onto a state memory address
   function automatic logic [ADDR_W-1:0] chan_addr(input logic [CH_W-1:0] ch);
      logic [CH_W+ADDR_W-1:0] wide;
      wide = {{ADDR_W{1'b0}}, ch};
      return wide[ADDR_W-1:0];
   endfunction

endpackage

/* rtl/core/mnpd_ram.sv */
// ----------------------------------------------------------------------------
// mnpd_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mnpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/multichannel_negative_peak_detector.sv */
// ----------------------------------------------------------------------------
// multichannel_negative_peak_detector: per-channel negative spike detector
// Flags local minima below a threshold, outside a refractory gap and within
// a per-block peak limit, on interleaved multichannel samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sample item per handshake (channel, value, number, block
//            start flag). Items may be interleaved across channels freely.
//   rsp_*  : one peak item for each sample whose predecessor on the same
//            channel is a reported peak; most samples give no item.
//   csr_*  : register writes (threshold, refractory gap, peak limit); always
//            ready, to be written only while the block is idle.
//   Throughput is one item per cycle unless stalled or sweeping: the per-channel
//   state memory is read at acceptance and written back as the item leaves the
//   lookup stage; the last write is forwarded so items on one channel chain.
//   A peak item passes the lookup stage and then the result register after its
//   sample item is accepted.
//   After reset the state memory is swept to its reset values, one entry a
//   cycle, over all CHANNELS (512) entries; req_ready stays low during the sweep.
//   When the receiver stalls, the result register holds and the pipeline
//   stage in front of it holds, so req_ready drops after at most one more
//   item.
// ----------------------------------------------------------------------------
module multichannel_negative_peak_detector (
   input  logic                                       clock,
   input  logic                                       reset,
   // Sample items
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [mnpd_pkg::CH_W-1:0]                  req_channel,
   input  logic signed [mnpd_pkg::SAMPLE_W-1:0]       req_sample_value,
   input  logic [mnpd_pkg::NUM_W-1:0]                 req_sample_number,
   input  logic                                       req_block_start,
   // Peak items
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [mnpd_pkg::CH_W-1:0]                  rsp_peak_channel,
   output logic signed [mnpd_pkg::PNUM_W-1:0]         rsp_peak_sample_number,
   output logic [mnpd_pkg::SAMPLE_W-1:0]              rsp_peak_amplitude,
   // Register writes
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [mnpd_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [mnpd_pkg::CSR_DATA_W-1:0]            csr_wdata
);

   import mnpd_pkg::*;

   // Configuration registers
   logic signed [SAMPLE_W-1:0] threshold_ff;
   logic [REFR_W-1:0]          refractory_ff;
   logic [CNT_W-1:0]           max_peaks_ff;

   // Clearing sweep
   logic                       clr_busy_ff;
   logic [ADDR_W-1:0]          clr_addr_ff;

   // Lookup stage
   logic                       s1_valid_ff;
   logic                       s1_hit_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [CH_W-1:0]            s1_ch_ff;
   logic signed [SAMPLE_W-1:0] s1_value_ff;
   logic [NUM_W-1:0]           s1_num_ff;
   logic                       s1_start_ff;

   // Write forwarding
   logic                       fwd_valid_ff;
   logic [ADDR_W-1:0]          fwd_addr_ff;
   chs_entry_type              fwd_data_ff;

   // Result register
   logic                       rsp_valid_ff;
   logic [CH_W-1:0]            rsp_ch_ff;
   logic signed [PNUM_W-1:0]   rsp_num_ff;
   logic [SAMPLE_W-1:0]        rsp_amp_ff;

   // Memory ports
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   chs_entry_type              ram_wr_data;
   logic                       ram_rd_en;
   logic [ENTRY_W-1:0]         ram_rd_data;

   // Datapath
   logic                       req_accept;
   logic                       s1_adv;
   logic                       s1_write;
   chs_entry_type              cur_entry;
   chs_entry_type              new_entry;
   logic [CNT_W-1:0]           count_eff;
   logic signed [GAP_W-1:0]    gap;
   logic                       found;
   logic [SAMPLE_W-1:0]        amplitude;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign s1_adv     = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_accept = req_valid && req_ready;
   assign s1_write   = s1_valid_ff && s1_adv && s1_hit_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         refractory_ff <= REFRACTORY_RESET;
         max_peaks_ff  <= MAX_PEAKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_THRESHOLD:  threshold_ff  <= $signed(csr_wdata[SAMPLE_W-1:0]);
            REG_REFRACTORY: refractory_ff <= csr_wdata[REFR_W-1:0];
            REG_MAX_PEAKS:  max_peaks_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sweep the state memory to reset values after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(CHANNELS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Advance the lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_hit_ff   <= (32'(req_channel) < CHANNELS);
         s1_addr_ff  <= chan_addr(req_channel);
         s1_ch_ff    <= req_channel;
         s1_value_ff <= req_sample_value;
         s1_num_ff   <= req_sample_number;
         s1_start_ff <= req_block_start;
      end
   end

   // State memory
   assign ram_rd_en   = req_accept;
   assign ram_wr_en   = clr_busy_ff || s1_write;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wr_data = clr_busy_ff ? ENTRY_RESET : new_entry;

   mnpd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (chan_addr(req_channel)),
      .rd_data (ram_rd_data)
   );

   // Hold the latest write to cover a read issued in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (ram_wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         fwd_addr_ff <= ram_wr_addr;
         fwd_data_ff <= ram_wr_data;
      end
   end

   // Judge the previous sample of the channel
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur_entry = fwd_data_ff;
      end else begin
         cur_entry = chs_entry_type'(ram_rd_data);
      end

      count_eff = s1_start_ff ? '0 : cur_entry.block_peak_count;

      gap = $signed({cur_entry.previous_number[PNUM_W-1], cur_entry.previous_number})
          - $signed({cur_entry.last_peak_number[PNUM_W-1], cur_entry.last_peak_number});

      found = s1_hit_ff
           && (cur_entry.older_sample > cur_entry.previous_sample)
           && (cur_entry.previous_sample <= s1_value_ff)
           && (cur_entry.previous_sample < threshold_ff)
           && (gap > $signed({{(GAP_W-REFR_W){1'b0}}, refractory_ff}))
           && (count_eff < max_peaks_ff);

      amplitude = SAMPLE_W'(-cur_entry.previous_sample);

      new_entry.older_sample     = cur_entry.previous_sample;
      new_entry.previous_sample  = s1_value_ff;
      new_entry.previous_number  = $signed({1'b0, s1_num_ff});
      new_entry.last_peak_number = found ? cur_entry.previous_number
                                         : cur_entry.last_peak_number;
      new_entry.block_peak_count = found ? count_eff + 1'b1 : count_eff;
   end

   // Load or drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_adv) begin
         rsp_valid_ff <= found;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv && found) begin
         rsp_ch_ff  <= s1_ch_ff;
         rsp_num_ff <= cur_entry.previous_number;
         rsp_amp_ff <= amplitude;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_peak_channel       = rsp_ch_ff;
   assign rsp_peak_sample_number = rsp_num_ff;
   assign rsp_peak_amplitude     = rsp_amp_ff;

`ifndef SYNTHESIS
   // No item enters while the memory is being swept
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("item accepted during clearing sweep");

   // The sweep and the write-back never share the write port
   a_no_stage_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_valid_ff)
      else $error("lookup stage busy during clearing sweep");

   // A stalled lookup stage keeps its item
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_addr_ff)
                                    && $stable(s1_num_ff)))
      else $error("lookup stage lost its item under stall");

   // A found peak reaches the result register
   a_peak_emitted: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_adv && found) |=> rsp_valid_ff)
      else $error("found peak not presented");
`endif

endmodule
